@@ sv/bbf_pkg.sv @@
package bbf_pkg;

    localparam logic [7:0] FRAME_CHAR    = 8'd95;
    localparam int         MAX_OUT_WORDS = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HASH_START,
        ST_HASH_WAIT,
        ST_MOD,
        ST_SET,
        ST_NEXT_Y,
        ST_EMIT,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic        start;
        logic [7:0]  a;
        logic [7:0]  b;
    } hash_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] m;
        logic [63:0] s;
    } hash_rsp_t;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] md5_k(input logic [5:0] i);
        case (i)
            6'd0: return 32'hd76aa478; 6'd1: return 32'he8c7b756;
            6'd2: return 32'h242070db; 6'd3: return 32'hc1bdceee;
            6'd4: return 32'hf57c0faf; 6'd5: return 32'h4787c62a;
            6'd6: return 32'ha8304613; 6'd7: return 32'hfd469501;
            6'd8: return 32'h698098d8; 6'd9: return 32'h8b44f7af;
            6'd10: return 32'hffff5bb1; 6'd11: return 32'h895cd7be;
            6'd12: return 32'h6b901122; 6'd13: return 32'hfd987193;
            6'd14: return 32'ha679438e; 6'd15: return 32'h49b40821;
            6'd16: return 32'hf61e2562; 6'd17: return 32'hc040b340;
            6'd18: return 32'h265e5a51; 6'd19: return 32'he9b6c7aa;
            6'd20: return 32'hd62f105d; 6'd21: return 32'h02441453;
            6'd22: return 32'hd8a1e681; 6'd23: return 32'he7d3fbc8;
            6'd24: return 32'h21e1cde6; 6'd25: return 32'hc33707d6;
            6'd26: return 32'hf4d50d87; 6'd27: return 32'h455a14ed;
            6'd28: return 32'ha9e3e905; 6'd29: return 32'hfcefa3f8;
            6'd30: return 32'h676f02d9; 6'd31: return 32'h8d2a4c8a;
            6'd32: return 32'hfffa3942; 6'd33: return 32'h8771f681;
            6'd34: return 32'h6d9d6122; 6'd35: return 32'hfde5380c;
            6'd36: return 32'ha4beea44; 6'd37: return 32'h4bdecfa9;
            6'd38: return 32'hf6bb4b60; 6'd39: return 32'hbebfbc70;
            6'd40: return 32'h289b7ec6; 6'd41: return 32'heaa127fa;
            6'd42: return 32'hd4ef3085; 6'd43: return 32'h04881d05;
            6'd44: return 32'hd9d4d039; 6'd45: return 32'he6db99e5;
            6'd46: return 32'h1fa27cf8; 6'd47: return 32'hc4ac5665;
            6'd48: return 32'hf4292244; 6'd49: return 32'h432aff97;
            6'd50: return 32'hab9423a7; 6'd51: return 32'hfc93a039;
            6'd52: return 32'h655b59c3; 6'd53: return 32'h8f0ccc92;
            6'd54: return 32'hffeff47d; 6'd55: return 32'h85845dd1;
            6'd56: return 32'h6fa87e4f; 6'd57: return 32'hfe2ce6e0;
            6'd58: return 32'ha3014314; 6'd59: return 32'h4e0811a1;
            6'd60: return 32'hf7537e82; 6'd61: return 32'hbd3af235;
            6'd62: return 32'h2ad7d2bb; default: return 32'heb86d391;
        endcase
    endfunction

    function automatic logic [31:0] sha_k(input logic [5:0] i);
        case (i)
            6'd0: return 32'h428a2f98; 6'd1: return 32'h71374491;
            6'd2: return 32'hb5c0fbcf; 6'd3: return 32'he9b5dba5;
            6'd4: return 32'h3956c25b; 6'd5: return 32'h59f111f1;
            6'd6: return 32'h923f82a4; 6'd7: return 32'hab1c5ed5;
            6'd8: return 32'hd807aa98; 6'd9: return 32'h12835b01;
            6'd10: return 32'h243185be; 6'd11: return 32'h550c7dc3;
            6'd12: return 32'h72be5d74; 6'd13: return 32'h80deb1fe;
            6'd14: return 32'h9bdc06a7; 6'd15: return 32'hc19bf174;
            6'd16: return 32'he49b69c1; 6'd17: return 32'hefbe4786;
            6'd18: return 32'h0fc19dc6; 6'd19: return 32'h240ca1cc;
            6'd20: return 32'h2de92c6f; 6'd21: return 32'h4a7484aa;
            6'd22: return 32'h5cb0a9dc; 6'd23: return 32'h76f988da;
            6'd24: return 32'h983e5152; 6'd25: return 32'ha831c66d;
            6'd26: return 32'hb00327c8; 6'd27: return 32'hbf597fc7;
            6'd28: return 32'hc6e00bf3; 6'd29: return 32'hd5a79147;
            6'd30: return 32'h06ca6351; 6'd31: return 32'h14292967;
            6'd32: return 32'h27b70a85; 6'd33: return 32'h2e1b2138;
            6'd34: return 32'h4d2c6dfc; 6'd35: return 32'h53380d13;
            6'd36: return 32'h650a7354; 6'd37: return 32'h766a0abb;
            6'd38: return 32'h81c2c92e; 6'd39: return 32'h92722c85;
            6'd40: return 32'ha2bfe8a1; 6'd41: return 32'ha81a664b;
            6'd42: return 32'hc24b8b70; 6'd43: return 32'hc76c51a3;
            6'd44: return 32'hd192e819; 6'd45: return 32'hd6990624;
            6'd46: return 32'hf40e3585; 6'd47: return 32'h106aa070;
            6'd48: return 32'h19a4c116; 6'd49: return 32'h1e376c08;
            6'd50: return 32'h2748774c; 6'd51: return 32'h34b0bcb5;
            6'd52: return 32'h391c0cb3; 6'd53: return 32'h4ed8aa4a;
            6'd54: return 32'h5b9cca4f; 6'd55: return 32'h682e6ff3;
            6'd56: return 32'h748f82ee; 6'd57: return 32'h78a5636f;
            6'd58: return 32'h84c87814; 6'd59: return 32'h8cc70208;
            6'd60: return 32'h90befffa; 6'd61: return 32'ha4506ceb;
            6'd62: return 32'hbef9a3f7; default: return 32'hc67178f2;
        endcase
    endfunction

    function automatic logic [4:0] md5_r(input logic [5:0] i);
        case ({i[5:4], i[1:0]})
            4'd0: return 5'd7;   4'd1: return 5'd12;  4'd2: return 5'd17;  4'd3: return 5'd22;
            4'd4: return 5'd5;   4'd5: return 5'd9;   4'd6: return 5'd14;  4'd7: return 5'd20;
            4'd8: return 5'd4;   4'd9: return 5'd11;  4'd10: return 5'd16; 4'd11: return 5'd23;
            4'd12: return 5'd6;  4'd13: return 5'd10; 4'd14: return 5'd15; default: return 5'd21;
        endcase
    endfunction

endpackage

@@ sv/bigram_bloom_filter_builder.sv @@
// Channel | Direction | tdata fields (low bit up)          | tuser / tlast
// s_axis  | in        | password_byte[7:0]                 | tlast = is_last
// m_axis  | out       | filter_word[63:0]                  | tuser = word_index, tlast = last_word
//
// Each byte hashes one bigram; the final byte hashes two. A bigram passes through the
// shared MD5/SHA-256 round unit, then 15 index remainders, each followed by the bit set,
// and a closing step, after which a plain byte frees the input. The final byte then
// loads the filter words into the output register, one per cycle while the receiver
// keeps up, and clears ceil(FILTER_BITS/64) words, one per cycle. Reset is asynchronous;
// it idles the state machine and clears the counters, the valid and second-hash flags
// and the filter. Output stalls hold the current word and keep the input closed until
// the last word has left.
module bigram_bloom_filter_builder
    import bbf_pkg::*;
#(
    parameter int FILTER_BITS = 1000,
    parameter int HASH_COUNT  = 15
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // password_byte[7:0]
    input  logic        s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // filter_word[63:0]
    output logic [3:0]  m_axis_tuser,   // word_index[3:0]
    output logic        m_axis_tlast    // last_word
);

    localparam int STORE_WORDS = (FILTER_BITS + 63) / 64;
    localparam int OUT_WORDS   = (STORE_WORDS < MAX_OUT_WORDS) ? STORE_WORDS : MAX_OUT_WORDS;
    localparam int WW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int IW = $clog2(FILTER_BITS);
    localparam int YW = $clog2(HASH_COUNT + 1);

    state_t state_reg, state_next;
    logic [7:0]  prev_reg;
    logic [7:0]  cur_reg;
    logic        last_reg;
    logic        second_reg;
    logic [63:0] s_reg, acc_reg;
    logic [YW-1:0] y_reg;
    logic [WW-1:0] word_reg;
    logic [IW-1:0] idx_reg;
    logic [63:0] filt_reg [STORE_WORDS];
    logic [63:0] out_reg;
    logic [3:0]  out_idx_reg;
    logic        out_last_reg;
    logic        out_valid_reg;

    hash_req_t hreq;
    hash_rsp_t hrsp;
    logic      mod_start, mod_done;
    logic [IW-1:0] mod_rem;

    bbf_hash u_hash (.clk(clk), .rst_n(rst_n), .req(hreq), .rsp(hrsp));

    bbf_mod #(.FILTER_BITS(FILTER_BITS)) u_mod (
        .clk(clk), .rst_n(rst_n), .start(mod_start), .value(acc_reg),
        .done(mod_done), .rem(mod_rem)
    );

    logic accept;
    assign accept = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:       if (accept) state_next = ST_HASH_START;
            ST_HASH_START: state_next = ST_HASH_WAIT;
            ST_HASH_WAIT:  if (hrsp.done) state_next = ST_NEXT_Y;
            ST_MOD:        if (mod_done) state_next = ST_SET;
            ST_SET:        state_next = ST_NEXT_Y;
            ST_NEXT_Y:
            begin
                if (y_reg != YW'(HASH_COUNT))
                    state_next = ST_MOD;
                else if (last_reg && !second_reg)
                    state_next = ST_HASH_START;
                else if (last_reg)
                    state_next = ST_EMIT;
                else
                    state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if ((!out_valid_reg || m_axis_tready) && word_reg == WW'(OUT_WORDS - 1))
                    state_next = ST_CLEAR;
            end
            ST_CLEAR:
            begin
                if (word_reg == WW'(STORE_WORDS - 1))
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE) && !out_valid_reg;
        hreq.start = (state_reg == ST_HASH_START);
        hreq.a     = second_reg ? cur_reg : prev_reg;
        hreq.b     = second_reg ? FRAME_CHAR : cur_reg;
        // Each remainder starts from the accumulator as it stands in the index step.
        mod_start  = (state_reg == ST_NEXT_Y) && (y_reg != YW'(HASH_COUNT));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prev_reg      <= FRAME_CHAR;
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
            word_reg      <= '0;
            y_reg         <= '0;
            for (int i = 0; i < STORE_WORDS; i++)
                filt_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_EMIT && (!out_valid_reg || m_axis_tready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cur_reg    <= s_axis_tdata;
                        last_reg   <= s_axis_tlast;
                        second_reg <= 1'b0;
                    end
                end
                ST_HASH_WAIT:
                begin
                    if (hrsp.done)
                    begin
                        s_reg   <= hrsp.s;
                        acc_reg <= hrsp.m;
                        y_reg   <= '0;
                    end
                end
                ST_MOD:
                    if (mod_done) idx_reg <= mod_rem;
                ST_SET:
                begin
                    filt_reg[WW'(idx_reg >> 6)][idx_reg[5:0]] <= 1'b1;
                    acc_reg <= acc_reg + s_reg;
                end
                ST_NEXT_Y:
                begin
                    if (y_reg != YW'(HASH_COUNT))
                        y_reg <= y_reg + YW'(1);
                    else if (last_reg && !second_reg)
                        second_reg <= 1'b1;
                    else
                    begin
                        prev_reg <= last_reg ? FRAME_CHAR : cur_reg;
                        word_reg <= '0;
                    end
                end
                ST_EMIT:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_reg       <= filt_reg[word_reg];
                        out_idx_reg   <= 4'(word_reg);
                        out_last_reg  <= (word_reg == WW'(OUT_WORDS - 1));
                        word_reg <= (word_reg == WW'(OUT_WORDS - 1)) ? '0 : word_reg + WW'(1);
                    end
                end
                ST_CLEAR:
                begin
                    filt_reg[word_reg] <= '0;
                    word_reg <= word_reg + WW'(1);
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;
    assign m_axis_tuser  = out_idx_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

@@ sv/bbf_hash.sv @@
// Shared round unit: one MD5 round and one SHA-256 round per cycle, 64 rounds per bigram.
// The done flag rises the cycle after the last round, while the tails are held.
module bbf_hash
    import bbf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  hash_req_t req,
    output hash_rsp_t rsp
);

    logic        busy_reg;
    logic [5:0]  round_reg;
    logic        done_reg;
    logic [31:0] ma_reg, mb_reg, mc_reg, md_reg;
    logic [31:0] sv_reg [8];
    logic [31:0] w_reg [16];
    logic [31:0] msg0_reg;

    logic [31:0] mf, mfs, mnb;
    logic [3:0]  g;
    logic [31:0] mw;
    logic [31:0] e1, ch, t1, a1, mj, t2, wnew, s0, s1;

    always_comb
    begin
        case (round_reg[5:4])
            2'd0: begin mf = (mb_reg & mc_reg) | (~mb_reg & md_reg); g = round_reg[3:0]; end
            2'd1: begin mf = (md_reg & mb_reg) | (~md_reg & mc_reg);
                        g = 4'(5 * round_reg + 1); end
            2'd2: begin mf = mb_reg ^ mc_reg ^ md_reg; g = 4'(3 * round_reg + 5); end
            default: begin mf = mc_reg ^ (mb_reg | ~md_reg); g = 4'(7 * round_reg); end
        endcase
        case (g)
            4'd0: mw = msg0_reg;
            4'd14: mw = 32'd16;
            default: mw = 32'd0;
        endcase
        mfs = mf + ma_reg + md5_k(round_reg) + mw;
        mnb = mb_reg + rotl32(mfs, md5_r(round_reg));
        e1 = rotr32(sv_reg[4], 6) ^ rotr32(sv_reg[4], 11) ^ rotr32(sv_reg[4], 25);
        ch = (sv_reg[4] & sv_reg[5]) ^ (~sv_reg[4] & sv_reg[6]);
        t1 = sv_reg[7] + e1 + ch + sha_k(round_reg) + w_reg[0];
        a1 = rotr32(sv_reg[0], 2) ^ rotr32(sv_reg[0], 13) ^ rotr32(sv_reg[0], 22);
        mj = (sv_reg[0] & sv_reg[1]) ^ (sv_reg[0] & sv_reg[2]) ^ (sv_reg[1] & sv_reg[2]);
        t2 = a1 + mj;
        s0 = rotr32(w_reg[1], 7) ^ rotr32(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr32(w_reg[14], 17) ^ rotr32(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wnew = w_reg[0] + s0 + w_reg[9] + s1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                round_reg <= '0;
            end
            else if (busy_reg)
            begin
                round_reg <= round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            msg0_reg <= {8'h00, 8'h80, req.b, req.a};
            ma_reg <= 32'h67452301; mb_reg <= 32'hefcdab89;
            mc_reg <= 32'h98badcfe; md_reg <= 32'h10325476;
            sv_reg[0] <= 32'h6a09e667; sv_reg[1] <= 32'hbb67ae85;
            sv_reg[2] <= 32'h3c6ef372; sv_reg[3] <= 32'ha54ff53a;
            sv_reg[4] <= 32'h510e527f; sv_reg[5] <= 32'h9b05688c;
            sv_reg[6] <= 32'h1f83d9ab; sv_reg[7] <= 32'h5be0cd19;
            w_reg[0]  <= {req.a, req.b, 8'h80, 8'h00};
            for (int i = 1; i < 15; i++)
                w_reg[i] <= 32'd0;
            w_reg[15] <= 32'd16;
        end
        else if (busy_reg)
        begin
            ma_reg <= md_reg; md_reg <= mc_reg; mc_reg <= mb_reg; mb_reg <= mnb;
            sv_reg[7] <= sv_reg[6]; sv_reg[6] <= sv_reg[5]; sv_reg[5] <= sv_reg[4];
            sv_reg[4] <= sv_reg[3] + t1;
            sv_reg[3] <= sv_reg[2]; sv_reg[2] <= sv_reg[1]; sv_reg[1] <= sv_reg[0];
            sv_reg[0] <= t1 + t2;
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= wnew;
        end
    end

    logic [31:0] mc_fin, md_fin, v6_fin, v7_fin;
    assign mc_fin = mc_reg + 32'h98badcfe;
    assign md_fin = md_reg + 32'h10325476;
    assign v6_fin = sv_reg[6] + 32'h1f83d9ab;
    assign v7_fin = sv_reg[7] + 32'h5be0cd19;

    assign rsp.done = done_reg;
    assign rsp.m = {mc_fin[7:0], mc_fin[15:8], mc_fin[23:16], mc_fin[31:24],
                    md_fin[7:0], md_fin[15:8], md_fin[23:16], md_fin[31:24]};
    assign rsp.s = {v6_fin[27:0], v7_fin, 4'h0};

endmodule

@@ sv/bbf_mod.sv @@
// Remainder of a 64-bit value by the filter size in registered steps. The first folds
// the four 16-bit chunks with their constant weights 2^(16k) mod FILTER_BITS into a
// 30-bit value, the second multiplies it by a rounded-up reciprocal, and the third
// subtracts quotient times divisor. The reciprocal is exact for every 30-bit value.
module bbf_mod
#(
    parameter int FILTER_BITS = 1000
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [63:0]                    value,
    output logic                           done,
    output logic [$clog2(FILTER_BITS)-1:0] rem
);

    localparam int LW = $clog2(FILTER_BITS);
    localparam int FW = 30;
    localparam int PW = 2 * FW + 1;
    localparam int SH = FW + LW;
    localparam logic [63:0]   DIV64   = 64'(FILTER_BITS);
    localparam logic [11:0]   P1      = 12'((64'd1 << 16) % DIV64);
    localparam logic [11:0]   P2      = 12'((64'd1 << 32) % DIV64);
    localparam logic [11:0]   P3      = 12'((64'd1 << 48) % DIV64);
    localparam logic [63:0]   RECIP64 = ((64'd1 << SH) + DIV64 - 64'd1) / DIV64;
    localparam logic [FW:0]   RECIP   = RECIP64[FW:0];
    localparam logic [FW-1:0] DIV_FW  = FW'(FILTER_BITS);

    logic          st1_reg, st2_reg, done_reg;
    logic [FW-1:0] fold_reg;
    logic [PW-1:0] prod_reg;
    logic [LW-1:0] rem_reg;

    logic [27:0]   pr1, pr2, pr3;
    logic [FW-1:0] fold_next;
    logic [FW-1:0] quo;
    logic [FW-1:0] qf;
    logic [FW-1:0] diff;

    assign pr1       = 28'(value[31:16]) * 28'(P1);
    assign pr2       = 28'(value[47:32]) * 28'(P2);
    assign pr3       = 28'(value[63:48]) * 28'(P3);
    assign fold_next = {14'd0, value[15:0]} + {2'd0, pr1} + {2'd0, pr2} + {2'd0, pr3};
    assign quo       = FW'(prod_reg >> SH);
    assign qf        = quo * DIV_FW;
    assign diff      = fold_reg - qf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_reg  <= 1'b0;
            st2_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            st1_reg  <= start;
            st2_reg  <= st1_reg;
            done_reg <= st2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            fold_reg <= fold_next;
        if (st1_reg)
            prod_reg <= PW'(fold_reg) * PW'(RECIP);
        if (st2_reg)
            rem_reg <= diff[LW-1:0];
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

@@ sv/bbf_checker.sv @@
module bbf_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [3:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input ready during output");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tuser))
        else $error("output dropped under stall");

    a_first_idx: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid) else $error("early output");

    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
        else $error("output after last word");

endmodule

bind bigram_bloom_filter_builder bbf_checker u_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
);
